// ----- sv/dvf_pkg.sv -----
// ----------------------------------------------------------------------------
// dvf_pkg
// Shared types and constants of the distinct value filter.
// ----------------------------------------------------------------------------
package dvf_pkg;

  localparam int WORD_SHIFT    = 5;
  localparam int WORD_BITS     = 1 << WORD_SHIFT;
  localparam int BYTE_KEY_BITS = 8;
  localparam int EPOCH_BITS    = 8;
  localparam int VALUE_BITS    = 64;
  localparam int POS_BITS      = 32;
  localparam int COUNT_BITS    = 32;
  localparam int MODE_BITS     = 2;

  localparam logic [MODE_BITS-1:0] MODE_BYTE  = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_SHORT = 2'd1;

  typedef logic [EPOCH_BITS-1:0] epoch_t;

  localparam epoch_t EPOCH_MAX = '1;

  // One seen-RAM word: set tag plus 32 seen bits.
  typedef struct packed {
    epoch_t                epoch;
    logic [WORD_BITS-1:0]  bits;
  } seen_word_t;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } state_e;

endpackage

// ----- sv/dvf_seen_ram.sv -----
// ----------------------------------------------------------------------------
// dvf_seen_ram
// Seen-bitmap storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dvf_seen_ram import dvf_pkg::*; #(
  parameter int ADDR_BITS = 11
) (
  input  logic                 clk_i,
  input  logic                 rd_en_i,
  input  logic [ADDR_BITS-1:0] rd_addr_i,
  output seen_word_t           rd_data_o,
  input  logic                 wr_en_i,
  input  logic [ADDR_BITS-1:0] wr_addr_i,
  input  seen_word_t           wr_data_i
);

  localparam int DEPTH = 1 << ADDR_BITS;

  seen_word_t mem_q [DEPTH];
  seen_word_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- sv/distinct_value_filter_unit.sv -----
// ----------------------------------------------------------------------------
// distinct_value_filter_unit
// Marks the first occurrence of each distinct value in a set; keeps a
// running distinct count. Byte/short key modes use a seen bitmap; the other
// modes (sorted and spare) compare against the previous value.
// ----------------------------------------------------------------------------
// channel   dir  tdata (low bit up)                     tuser
// s_axis    in   value[63:0], position[95:64]           first_of_set
// m_axis    out  row_out[31:0], distinct_count[63:32]   keep
// cfg       in   mode[1:0]                              -
//
// One item per cycle while m_axis is ready and no clearing pass runs; items
// pass the stage-1 register, then the output register. The seen RAM is read
// at accept and written when stage 1 fires, with forwarding for equal words.
// Sets are cleared by an epoch tag per RAM word. After reset, and before the
// 256th set start and every 255th one after it, a clearing pass over all
// 2^(KEY_BITS-5) RAM words holds off s_axis. m_axis stalls back up through a single output register.
// ----------------------------------------------------------------------------
module distinct_value_filter_unit import dvf_pkg::*; #(
  parameter int KEY_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [MODE_BITS-1:0]  cfg_data_i,      // mode
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [95:0]           s_axis_tdata_i,  // value, position
  input  logic                  s_axis_tuser_i,  // first_of_set
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [63:0]           m_axis_tdata_o,  // row_out, distinct_count
  output logic                  m_axis_tuser_o   // keep
);

  localparam int ADDR_BITS = KEY_BITS - WORD_SHIFT;

  logic [MODE_BITS-1:0]  mode_q;
  state_e                state_q, state_d;
  logic [ADDR_BITS-1:0]  sweep_addr_q, sweep_addr_d;
  epoch_t                epoch_q, epoch_d;

  logic                  s1_valid_q;
  logic [VALUE_BITS-1:0] s1_value_q;
  logic [POS_BITS-1:0]   s1_pos_q;
  logic                  s1_first_q;
  logic [ADDR_BITS-1:0]  s1_addr_q;
  logic [WORD_SHIFT-1:0] s1_bit_q;
  epoch_t                s1_epoch_q;
  logic                  s1_fwd_q;
  logic [WORD_BITS-1:0]  s1_fwd_bits_q;

  logic [VALUE_BITS-1:0] prev_q;
  logic                  have_prev_q;
  logic [COUNT_BITS-1:0] count_q;

  logic                  out_valid_q;
  logic                  out_keep_q;
  logic [POS_BITS-1:0]   out_row_q;
  logic [COUNT_BITS-1:0] out_count_q;

  logic                  bitmap_mode;
  logic                  in_accept;
  logic                  s1_fire;
  logic                  wrap_block;
  logic [VALUE_BITS-1:0] in_value;
  logic [KEY_BITS-1:0]   in_key;
  logic [ADDR_BITS-1:0]  in_addr;
  seen_word_t            rd_word;
  logic [WORD_BITS-1:0]  old_bits;
  logic [WORD_BITS-1:0]  bit_mask;
  logic [WORD_BITS-1:0]  new_bits;
  logic                  keep;
  logic [COUNT_BITS-1:0] count_base;
  logic [COUNT_BITS-1:0] count_new;
  logic                  have_base;
  logic [VALUE_BITS-1:0] prev_base;
  logic                  wr_en;
  logic [ADDR_BITS-1:0]  wr_addr;
  seen_word_t            wr_word;

  assign cfg_ready_o = 1'b1;
  assign bitmap_mode = (mode_q == MODE_BYTE) || (mode_q == MODE_SHORT);
  assign in_value    = s_axis_tdata_i[63:0];
  assign in_key      = (mode_q == MODE_BYTE) ? KEY_BITS'(in_value[BYTE_KEY_BITS-1:0])
                                             : in_value[KEY_BITS-1:0];
  assign in_addr     = in_key[KEY_BITS-1:WORD_SHIFT];

  // a new epoch past the top must wait for a clearing pass
  assign wrap_block      = s_axis_tuser_i && (epoch_q == EPOCH_MAX);
  assign s1_fire         = s1_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = (state_q == ST_RUN) && (!s1_valid_q || s1_fire) && !wrap_block;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  // ---- seen RAM ----
  dvf_seen_ram #(
    .ADDR_BITS (ADDR_BITS)
  ) u_seen_ram (
    .clk_i     (clk_i),
    .rd_en_i   (in_accept),
    .rd_addr_i (in_addr),
    .rd_data_o (rd_word),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_word)
  );

  // ---- stage 1: test-and-set, sorted compare, count ----
  always_comb begin
    if (s1_fwd_q) begin
      old_bits = s1_fwd_bits_q;
    end else if (rd_word.epoch == s1_epoch_q) begin
      old_bits = rd_word.bits;
    end else begin
      old_bits = '0;
    end
    bit_mask   = WORD_BITS'(1) << s1_bit_q;
    new_bits   = old_bits | bit_mask;
    have_base  = s1_first_q ? 1'b0 : have_prev_q;
    prev_base  = s1_first_q ? '0 : prev_q;
    count_base = s1_first_q ? '0 : count_q;
    if (bitmap_mode) begin
      keep = (old_bits & bit_mask) == '0;
    end else begin
      keep = !have_base || (s1_value_q != prev_base);
    end
    count_new = (keep && (count_base != '1)) ? count_base + COUNT_BITS'(1) : count_base;
  end

  always_comb begin
    if (state_q == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = sweep_addr_q;
      wr_word = '0;
    end else begin
      wr_en   = s1_fire && bitmap_mode;
      wr_addr = s1_addr_q;
      wr_word = '{epoch: s1_epoch_q, bits: new_bits};
    end
  end

  // ---- sweep / epoch control ----
  always_comb begin
    state_d      = state_q;
    sweep_addr_d = sweep_addr_q;
    epoch_d      = epoch_q;
    case (state_q)
      ST_CLEAR: begin
        sweep_addr_d = sweep_addr_q + ADDR_BITS'(1);
        if (sweep_addr_q == '1) begin
          state_d = ST_RUN;
          epoch_d = '0;
        end
      end
      ST_RUN: begin
        if (in_accept && s_axis_tuser_i) begin
          epoch_d = epoch_q + EPOCH_BITS'(1);
        end else if (s_axis_tvalid_i && wrap_block && !s1_valid_q) begin
          state_d      = ST_CLEAR;
          sweep_addr_d = '0;
        end
      end
      default: begin
        state_d      = ST_CLEAR;
        sweep_addr_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      sweep_addr_q <= '0;
      epoch_q      <= '0;
      mode_q       <= MODE_BYTE;
      s1_valid_q   <= 1'b0;
      prev_q       <= '0;
      have_prev_q  <= 1'b0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      sweep_addr_q <= sweep_addr_d;
      epoch_q      <= epoch_d;
      if (cfg_valid_i && cfg_ready_o) begin
        mode_q <= cfg_data_i;
      end
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        count_q <= count_new;
        if (bitmap_mode) begin
          prev_q      <= prev_base;
          have_prev_q <= have_base;
        end else begin
          prev_q      <= s1_value_q;
          have_prev_q <= 1'b1;
        end
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_value_q    <= in_value;
      s1_pos_q      <= s_axis_tdata_i[95:64];
      s1_first_q    <= s_axis_tuser_i;
      s1_addr_q     <= in_addr;
      s1_bit_q      <= in_key[WORD_SHIFT-1:0];
      s1_epoch_q    <= epoch_d;
      s1_fwd_q      <= wr_en && (wr_addr == in_addr) && !s_axis_tuser_i;
      s1_fwd_bits_q <= new_bits;
    end
    if (s1_fire) begin
      out_keep_q  <= keep;
      out_row_q   <= s1_pos_q;
      out_count_q <= count_new;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_count_q, out_row_q};
  assign m_axis_tuser_o  = out_keep_q;

  // ---- assertions ----
  a_sweep_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !s1_valid_q)
    else $error("clearing pass overlaps a pending item");

  a_no_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && s_axis_tuser_i) |-> (epoch_q != EPOCH_MAX))
    else $error("epoch wrapped without a clearing pass");

  a_fire_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_valid_q)
    else $error("result lost between stage and output register");

  a_count_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && !s1_first_q) |=> (count_q >= $past(count_q)))
    else $error("distinct count went down within a set");

endmodule

// ----- tb/sv/tb_distinct_value_filter_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_distinct_value_filter_unit
// Streams value/position items through the filter in byte-key, short-key,
// sorted and spare modes. An in-bench model of the seen bitmap, previous
// value and running count predicts keep/row/count for each accepted item;
// results are checked in order under random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_distinct_value_filter_unit import dvf_pkg::*;;

  localparam int KEY_BITS    = 16;
  localparam int STALL_LIMIT = 20000;

  typedef logic [MODE_BITS-1:0] mode_t;

  localparam mode_t MODE_SORTED = 2'd2;
  localparam mode_t MODE_SPARE  = 2'd3;

  typedef struct {
    logic [VALUE_BITS-1:0] value;
    logic [POS_BITS-1:0]   position;
    logic                  first_of_set;
  } column_item_t;

  typedef struct {
    logic                  keep;
    logic [POS_BITS-1:0]   row;
    logic [COUNT_BITS-1:0] count;
  } distinct_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [MODE_BITS-1:0]  cfg_data_i = '0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [95:0]           s_axis_tdata_i = '0;  // value[63:0], position[95:64]
  logic                  s_axis_tuser_i = 1'b0; // first_of_set
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [63:0]           m_axis_tdata_o;       // row_out[31:0], distinct_count[63:32]
  logic                  m_axis_tuser_o;       // keep

  distinct_value_filter_unit #(.KEY_BITS(KEY_BITS)) uut (.*);

  // model state
  bit                    seen_map [0:(1<<KEY_BITS)-1];
  int unsigned           touched_keys [$];
  logic [VALUE_BITS-1:0] last_value = '0;
  bit                    have_last = 1'b0;
  logic [COUNT_BITS-1:0] running_count = '0;
  mode_t                 filter_mode = MODE_BYTE;

  column_item_t          pending_items [$];
  distinct_result_t      expected_results [$];

  int  items_pushed = 0;
  int  items_taken = 0;
  int  results_seen = 0;
  int  keeps_seen = 0;
  int  sets_started = 0;
  int  mismatches = 0;
  int  idle_in_pct = 0;
  int  idle_out_pct = 0;
  int  stall_cycles = 0;
  logic item_taken = 1'b0;
  logic cfg_taken = 1'b0;
  logic [VALUE_BITS-1:0] last_gen = '0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic predict_distinct(input column_item_t it);
    distinct_result_t r;
    int unsigned key;
    if (it.first_of_set) begin
      foreach (touched_keys[i]) seen_map[touched_keys[i]] = 1'b0;
      touched_keys.delete();
      last_value    = '0;
      have_last     = 1'b0;
      running_count = '0;
      sets_started++;
    end
    if (filter_mode == MODE_BYTE || filter_mode == MODE_SHORT) begin
      key = (filter_mode == MODE_BYTE) ? 32'(it.value[BYTE_KEY_BITS-1:0])
                                       : 32'(it.value[KEY_BITS-1:0]);
      r.keep = !seen_map[key];
      if (r.keep) begin
        seen_map[key] = 1'b1;
        touched_keys.push_back(key);
      end
    end else begin
      r.keep     = !have_last || (it.value != last_value);
      last_value = it.value;
      have_last  = 1'b1;
    end
    if (r.keep && running_count != '1) running_count++;
    r.row   = it.position;
    r.count = running_count;
    expected_results.push_back(r);
  endtask

  // driver
  always @(negedge clk_i) begin : drive_items
    column_item_t nxt;
    if (rst_ni && (!s_axis_tvalid_i || item_taken)) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= idle_in_pct) begin
        nxt = pending_items.pop_front();
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= {nxt.position, nxt.value};
        s_axis_tuser_i  <= nxt.first_of_set;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
    m_axis_tready_i <= ($urandom_range(99) >= idle_out_pct);
  end

  // monitor
  always @(posedge clk_i) begin : check_results
    distinct_result_t want;
    column_item_t     got_item;
    item_taken <= rst_ni && s_axis_tvalid_i && s_axis_tready_o;
    cfg_taken  <= rst_ni && cfg_valid_i && cfg_ready_o;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result with no item outstanding: row %0h", m_axis_tdata_o[31:0]);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (want.keep) keeps_seen++;
          if (m_axis_tuser_o !== want.keep) begin
            $error("keep: expected %0d, got %0d", want.keep, m_axis_tuser_o);
            mismatches++;
          end
          if (m_axis_tdata_o[31:0] !== want.row) begin
            $error("row_out: expected %0h, got %0h", want.row, m_axis_tdata_o[31:0]);
            mismatches++;
          end
          if (m_axis_tdata_o[63:32] !== want.count) begin
            $error("distinct_count: expected %0d, got %0d", want.count,
                   m_axis_tdata_o[63:32]);
            mismatches++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) filter_mode = cfg_data_i;
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        got_item.value        = s_axis_tdata_i[63:0];
        got_item.position     = s_axis_tdata_i[95:64];
        got_item.first_of_set = s_axis_tuser_i;
        predict_distinct(got_item);
        items_taken++;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic queue_item(input logic [VALUE_BITS-1:0] v, input logic [POS_BITS-1:0] p,
                            input logic first);
    column_item_t it;
    it.value        = v;
    it.position     = p;
    it.first_of_set = first;
    pending_items.push_back(it);
    items_pushed++;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (items_taken != items_pushed || expected_results.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_mode(input mode_t m);
    @(negedge clk_i);
    cfg_data_i  <= m;
    cfg_valid_i <= 1'b1;
    do @(negedge clk_i);
    while (!cfg_taken);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [VALUE_BITS-1:0] gen_value(input mode_t m);
    logic [VALUE_BITS-1:0] v;
    int pick;
    v    = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (m == MODE_BYTE) begin
      if (pick < 50) v[7:0] = 8'($urandom_range(0, 7));
    end else if (m == MODE_SHORT) begin
      if (pick < 40) v[15:0] = 16'($urandom_range(0, 31));
      else if (pick < 60) v[15:0] = 16'hFFFF - 16'($urandom_range(0, 15));
    end else begin
      if (pick < 45) v = last_gen;
      else if (pick < 65) v = last_gen ^ (64'd1 << $urandom_range(63));
    end
    last_gen = v;
    return v;
  endfunction

  initial begin : stimulus
    mode_t m;
    int    set_pct;
    int    n_items;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    idle_in_pct  = 30;
    idle_out_pct = 66;

    // byte keys from reset mode; upper bits ignored
    queue_item(64'h0, 32'h0, 1'b1);
    queue_item(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    queue_item(64'h100, 32'h1, 1'b0);
    queue_item(64'hFFFF_FFFF_FFFF_FF00, 32'h2, 1'b0);
    wait_drained();
    // short keys share the bitmap, set kept across the mode change
    write_mode(MODE_SHORT);
    queue_item(64'h100, 32'h3, 1'b0);
    queue_item(64'h0, 32'h4, 1'b0);
    queue_item(64'hFFFF_0000_0001_FFFF, 32'h5, 1'b0);
    queue_item(64'h0000_0000_0000_FFFF, 32'h6, 1'b0);
    queue_item(64'hFF, 32'h7, 1'b1);
    wait_drained();
    // sorted: no previous held yet, then full-width compare
    write_mode(MODE_SORTED);
    queue_item(64'hFF, 32'h8, 1'b0);
    queue_item(64'hFF, 32'h9, 1'b0);
    queue_item(64'h8000_0000_0000_00FF, 32'hA, 1'b0);
    queue_item(64'h8000_0000_0000_00FF, 32'hB, 1'b1);
    wait_drained();
    // spare mode acts as sorted; new set with value equal to cleared previous
    write_mode(MODE_SPARE);
    queue_item(64'h8000_0000_0000_00FF, 32'hC, 1'b0);
    queue_item(64'h0, 32'hD, 1'b0);
    queue_item(64'h0, 32'hE, 1'b0);
    queue_item(64'h0, 32'hF, 1'b1);
    wait_drained();
    write_mode(MODE_BYTE);
    queue_item(64'h55, 32'h10, 1'b0);
    queue_item(64'hAA55, 32'h11, 1'b0);

    for (int phase = 0; phase < 14; phase++) begin
      wait_drained();
      if (phase == 5) begin
        idle_in_pct  = 66;
        idle_out_pct = 30;
      end else if (phase == 10) begin
        idle_in_pct  = 0;
        idle_out_pct = 0;
      end
      case (phase % 4)
        0:       m = MODE_BYTE;
        1:       m = MODE_SORTED;
        2:       m = MODE_SHORT;
        default: m = MODE_SPARE;
      endcase
      write_mode(m);
      set_pct = (phase == 4 || phase == 8) ? 1 : 30;
      n_items = 100 + int'($urandom_range(0, 20));
      for (int i = 0; i < n_items; i++)
        queue_item(gen_value(m), $urandom,
                   (i == 0) ? 1'($urandom_range(1)) : ($urandom_range(99) < set_pct));
    end

    wait_drained();
    repeat (10) @(negedge clk_i);
    $display("Checked %0d items, %0d kept, over %0d sets in all four modes",
             results_seen, keeps_seen, sets_started);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
